>>> hdl/dlmwc_pkg.sv
// Shared types, constants and coefficient tables for the dual lag-8 multiply-with-carry generator.
package dlmwc_pkg;

  localparam int HIST_DEPTH = 10;
  localparam int COEF_N     = 8;
  localparam int SEED_STEPS = 18;
  localparam int LANE_STEPS = 9;

  typedef logic [15:0] hist_word_t;
  typedef logic [3:0]  hist_idx_t;
  typedef logic [4:0]  seed_step_t;
  typedef logic [13:0] coef_t;
  typedef coef_t       coef_arr_t [COEF_N];

  localparam logic [14:0] SEED_MULT  = 15'd30903;
  localparam logic [31:0] FULL_SCALE = 32'hFFFF_FFFF;
  localparam logic [14:0] CARRY_MASK = 15'h7FFF;

  localparam coef_arr_t FIRST_COEF = '{
    14'd1941, 14'd1860, 14'd1812, 14'd1776, 14'd1492, 14'd1215, 14'd1066, 14'd12013
  };
  localparam coef_arr_t SECOND_COEF = '{
    14'd1111, 14'd2222, 14'd3333, 14'd4444, 14'd5555, 14'd6666, 14'd7777, 14'd9272
  };

  typedef struct packed {
    logic       en;
    hist_idx_t  idx;
    hist_word_t data;
  } seed_wr_t;

endpackage

>>> hdl/dlmwc_lane.sv
// One lag-8 multiply-with-carry generator: history registers, seeding writes and the update step.
module dlmwc_lane
  import dlmwc_pkg::*;
(
  input  logic       clk,
  input  seed_wr_t   seed_wr,
  input  logic       step_en,
  input  coef_arr_t  coef,
  output hist_word_t new_word
);

  hist_word_t  hist [HIST_DEPTH];
  logic [31:0] sum;

  always_comb begin
    sum = 32'(hist[0]);
    for (int i = 0; i < COEF_N; i++) begin
      sum = sum + 32'(coef[i]) * 32'(hist[i + 1]);
    end
  end

  assign new_word = sum[15:0];

  always_ff @(posedge clk) begin
    if (seed_wr.en) begin
      if (seed_wr.idx == '0) begin
        // The carry word is held to 15 bits and the oldest word starts at zero.
        hist[0]              <= {1'b0, seed_wr.data[14:0] & CARRY_MASK};
        hist[HIST_DEPTH - 1] <= '0;
      end else begin
        hist[seed_wr.idx] <= seed_wr.data;
      end
    end else if (step_en) begin
      hist[0] <= sum[31:16];
      hist[1] <= sum[15:0];
      for (int i = 2; i < HIST_DEPTH; i++) begin
        hist[i] <= hist[i - 1];
      end
    end
  end

endmodule

>>> hdl/dual_lag8_mwc_random_generator.sv
// Top level of the dual lag-8 multiply-with-carry random generator with scaled output.
// A transaction is registered in word1/max1, then in word2/prod2, then in the output registers with out_valid.
// Throughput: one transaction per cycle while no seeding pass or output stall holds in_ready low.
// Reset and every seed write start a seeding pass, one recurrence step per cycle,
// during which in_ready is low; reset seeds as if the value 1 had been written.
// Seed writes are expected only while no transaction is in flight.
module dual_lag8_mwc_random_generator
  import dlmwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] max_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_word,
  output logic [31:0] scaled_value
);

  logic        seed_busy;
  seed_step_t  seed_step;
  hist_word_t  seed_s;
  logic [31:0] seed_n;
  logic [31:0] seed_n_next;
  seed_wr_t    first_wr;
  seed_wr_t    second_wr;

  logic        v1, v2;
  logic        en1, en2, en3;
  logic        accept;
  logic [31:0] word1, max1, word2;
  logic [63:0] prod2;
  hist_word_t  first_word, second_word;
  logic [32:0] fold;
  logic [1:0]  fold_carry;

  assign seed_n_next = 32'(SEED_MULT) * 32'(seed_s) + (seed_n >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_busy <= 1'b1;
      seed_step <= '0;
      seed_s    <= 16'd1;
      seed_n    <= 32'd1;
    end else if (cfg_we) begin
      seed_busy <= 1'b1;
      seed_step <= '0;
      seed_s    <= seed[15:0];
      seed_n    <= {1'b0, seed[30:0]};
    end else if (seed_busy) begin
      seed_s    <= seed_n_next[15:0];
      seed_n    <= seed_n_next;
      seed_step <= seed_step + 5'd1;
      if (seed_step == 5'(SEED_STEPS - 1)) begin
        seed_busy <= 1'b0;
      end
    end
  end

  always_comb begin
    first_wr.en    = seed_busy && (seed_step < 5'(LANE_STEPS));
    first_wr.idx   = seed_step[3:0];
    first_wr.data  = seed_n_next[15:0];
    second_wr.en   = seed_busy && (seed_step >= 5'(LANE_STEPS));
    second_wr.idx  = 4'(seed_step - 5'(LANE_STEPS));
    second_wr.data = seed_n_next[15:0];
  end

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1 && !seed_busy;
  assign accept   = in_valid && in_ready;

  dlmwc_lane u_first (
    .clk      (clk),
    .seed_wr  (first_wr),
    .step_en  (accept),
    .coef     (FIRST_COEF),
    .new_word (first_word)
  );

  dlmwc_lane u_second (
    .clk      (clk),
    .seed_wr  (second_wr),
    .step_en  (accept),
    .coef     (SECOND_COEF),
    .new_word (second_word)
  );

  // The product divided by 2^32-1 is its high half plus a small correction from folding the halves.
  always_comb begin
    fold = {1'b0, prod2[63:32]} + {1'b0, prod2[31:0]};
    priority if (fold >= {FULL_SCALE, 1'b0}) begin
      fold_carry = 2'd2;
    end else if (fold >= {1'b0, FULL_SCALE}) begin
      fold_carry = 2'd1;
    end else begin
      fold_carry = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
    if (en1 && accept) begin
      word1 <= {first_word, second_word};
      max1  <= max_value;
    end
    if (en2) begin
      word2 <= word1;
      prod2 <= 64'(word1) * 64'(max1);
    end
    if (en3) begin
      random_word  <= word2;
      scaled_value <= prod2[63:32] + 32'(fold_carry);
    end
  end

endmodule

>>> hdl/dlmwc_checker.sv
// Port-level assertions for the dual lag-8 multiply-with-carry generator, bound to the top level.
module dlmwc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] random_word,
  input logic [31:0] scaled_value
);

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(random_word) && $stable(scaled_value))
    else $error("Stalled result changed or was dropped.");

  a_reset_seeds : assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("Transaction accepted during seeding after reset.");

  a_cfg_seeds : assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("Transaction accepted during seeding after a seed write.");

  a_latency : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("Result did not appear three cycles after its transaction.");

  a_scaled_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid && random_word != 32'hFFFF_FFFF |-> scaled_value != 32'hFFFF_FFFF)
    else $error("Scaled value reached full scale without a full-scale word.");

endmodule

bind dual_lag8_mwc_random_generator dlmwc_checker u_dlmwc_checker (.*);
